// File: hdl/drf_pkg.sv
`default_nettype none

package drf_pkg;

   localparam int SLOT_W  = 10;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 10;

   localparam logic [BYTE_W-1:0] NULL_CODE = 8'h00;
   localparam logic [BYTE_W-1:0] RDM_CODE  = 8'hCC;
   localparam logic [BYTE_W-1:0] DISC_CODE = 8'hFE;

   // Highest length an RDM length byte can set: 255 plus 2.
   localparam int RDM_LEN_MAX = 257;

   typedef enum logic [1:0] {
      KIND_DMX  = 2'd0,
      KIND_RDM  = 2'd1,
      KIND_NONE = 2'd2
   } frame_kind_type;

   typedef struct packed {
      logic                byte_valid;
      logic [SLOT_W-1:0]   slot_index;
      logic [BYTE_W-1:0]   slot_value;
      logic                frame_done;
      frame_kind_type      frame_kind;
      logic [COUNT_W-1:0]  frame_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/drf_framer.sv
`default_nettype none

module drf_framer #(
   parameter int MAX_FRAME = 513
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             item_break,
   input  wire logic [7:0]       item_byte,
   input  wire logic             rdm_active,
   output drf_pkg::rsp_type      res
);
   import drf_pkg::*;

   localparam int LEN_MAX = (MAX_FRAME > RDM_LEN_MAX) ? MAX_FRAME : RDM_LEN_MAX;
   localparam int CW      = $clog2(LEN_MAX + 1);
   localparam int WW      = (CW > SLOT_W) ? CW : SLOT_W;

   logic          receiving_ff, receiving_in;
   logic [CW-1:0] slot_cnt_ff, slot_cnt_in;
   logic [CW-1:0] frame_len_ff, frame_len_in;
   logic [7:0]    start_code_ff, start_code_in;

   logic [CW-1:0] cnt_next;
   logic [CW-1:0] len_eff;
   logic [7:0]    code_eff;
   logic          drop;

   function automatic logic [SLOT_W-1:0] to_field(input logic [CW-1:0] v);
      logic [WW-1:0] w;
      w = WW'(v);
      return w[SLOT_W-1:0];
   endfunction

   always_comb begin
      receiving_in  = receiving_ff;
      slot_cnt_in   = slot_cnt_ff;
      frame_len_in  = frame_len_ff;
      start_code_in = start_code_ff;
      res           = '0;
      cnt_next      = slot_cnt_ff + CW'(1);
      code_eff      = (slot_cnt_ff == '0) ? item_byte : start_code_ff;
      len_eff       = frame_len_ff;
      drop          = 1'b0;

      if (slot_cnt_ff == CW'(2)) begin
         if (code_eff == RDM_CODE) begin
            if (!rdm_active) begin
               len_eff = CW'({1'b0, item_byte} + 9'd2);
            end
         end else if (code_eff == DISC_CODE) begin
            len_eff = CW'(MAX_FRAME);
         end else if (code_eff != NULL_CODE) begin
            drop = 1'b1;
         end
      end

      if (item_break) begin
         // Only a null start code frame with data slots is closed by a break.
         if (receiving_ff && slot_cnt_ff > CW'(1) && start_code_ff == NULL_CODE) begin
            res.frame_done = 1'b1;
            if (!rdm_active) begin
               res.frame_kind  = KIND_DMX;
               res.frame_count = to_field(slot_cnt_ff - CW'(1));
            end else begin
               res.frame_kind  = KIND_NONE;
               res.frame_count = to_field(slot_cnt_ff);
            end
         end
         receiving_in = 1'b1;
         slot_cnt_in  = '0;
         frame_len_in = CW'(MAX_FRAME);
      end else if (receiving_ff) begin
         res.byte_valid = 1'b1;
         res.slot_index = to_field(slot_cnt_ff);
         res.slot_value = item_byte;
         start_code_in  = code_eff;
         frame_len_in   = len_eff;
         slot_cnt_in    = cnt_next;
         if (drop) begin
            receiving_in    = 1'b0;
            res.frame_done  = 1'b1;
            res.frame_kind  = KIND_NONE;
            res.frame_count = to_field(cnt_next);
         end else if (cnt_next >= len_eff) begin
            receiving_in   = 1'b0;
            res.frame_done = 1'b1;
            if (!rdm_active && code_eff == NULL_CODE) begin
               res.frame_kind  = KIND_DMX;
               res.frame_count = to_field(slot_cnt_ff);
            end else if (!rdm_active && code_eff == RDM_CODE) begin
               res.frame_kind  = KIND_RDM;
               res.frame_count = to_field(len_eff);
            end else begin
               res.frame_kind  = KIND_NONE;
               res.frame_count = to_field(cnt_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         slot_cnt_ff   <= '0;
         frame_len_ff  <= CW'(MAX_FRAME);
         start_code_ff <= NULL_CODE;
      end else if (step) begin
         receiving_ff  <= receiving_in;
         slot_cnt_ff   <= slot_cnt_in;
         frame_len_ff  <= frame_len_in;
         start_code_ff <= start_code_in;
      end
   end

   // A running frame always ends before its slot count reaches the length.
   a_cnt_below_len: assert property (@(posedge clock) disable iff (reset)
      receiving_ff |-> slot_cnt_ff < frame_len_ff)
      else $error("slot counter reached frame length while receiving");

   // A frame that ends on a data byte leaves the framer waiting for a break.
   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      step && !item_break && res.frame_done |=> !receiving_ff)
      else $error("framer still receiving after frame end");

   // A break always rearms reception from slot zero.
   a_break_rearms: assert property (@(posedge clock) disable iff (reset)
      step && item_break |=> receiving_ff && slot_cnt_ff == '0)
      else $error("break did not restart the frame");

endmodule

`default_nettype wire

// File: hdl/drf_out_skid.sv
`default_nettype none

module drf_out_skid (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire drf_pkg::rsp_type push_data,
   output logic               push_ready,
   output logic               out_valid,
   input  wire logic          out_ready,
   output drf_pkg::rsp_type   out_data
);
   import drf_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;

   // Ready depends only on the spare entry, so the downstream ready never
   // reaches the upstream side combinationally.
   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("spare entry holds an item while the output is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !out_ready && push))
      else $error("spare entry filled without a stalled output");

endmodule

`default_nettype wire

// File: hdl/dmx_rdm_frame_receiver.sv
`default_nettype none

// DMX512/RDM receive framer. Each input item is a break or a received data
// byte; each gives exactly one result item that reports the stored byte with
// its slot index and, when a frame ends, the frame kind and count. The block
// takes one item per clock cycle when the result side keeps up. An accepted
// item is held in the input register; the framer logic feeds its result into
// the output register when the output buffer has room, and the output register
// then offers it on rsp_tvalid.
// A two-entry output buffer keeps req_tready independent of rsp_tready. The
// register csr_wr_data is written whenever csr_wr_en is high and must only
// change while no item is in flight.
module dmx_rdm_frame_receiver #(
   parameter int MAX_FRAME = 513
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,    // rdm_transaction_active
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,      // [7:0] rx_byte
   input  wire logic        req_tuser,      // [0] req_type (1 = break)
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,      // [9:0] slot_index, [17:10] slot_value,
                                            // [27:18] frame_count, [31:28] zero
   output logic [3:0]       rsp_tuser       // [0] byte_valid, [1] frame_done,
                                            // [3:2] frame_kind
);
   import drf_pkg::*;

   logic       rdm_active_ff;
   logic       in_valid_ff;
   logic       in_break_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       out_room;
   rsp_type    framed;
   rsp_type    rsp;

   assign advance    = in_valid_ff && out_room;
   assign req_tready = !in_valid_ff || out_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         rdm_active_ff <= 1'b0;
      end else if (csr_wr_en) begin
         rdm_active_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_break_ff <= req_tuser;
         in_byte_ff  <= req_tdata;
      end
   end

   drf_framer #(
      .MAX_FRAME (MAX_FRAME)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item_break (in_break_ff),
      .item_byte  (in_byte_ff),
      .rdm_active (rdm_active_ff),
      .res        (framed)
   );

   drf_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .push_data  (framed),
      .push_ready (out_room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp)
   );

   assign rsp_tdata = {4'b0000, rsp.frame_count, rsp.slot_value, rsp.slot_index};
   assign rsp_tuser = {rsp.frame_kind, rsp.frame_done, rsp.byte_valid};

endmodule

`default_nettype wire
